// ===== sv/tlpa_pkg.sv =====
package tlpa_pkg;

    // Sensor sample width and the fixed calibration widths
    localparam int SAMPLE_BITS = 10;
    localparam int LEVEL_W     = 16;
    localparam int HEIGHT_W    = 8;
    localparam int PCT_W       = 8;
    localparam int CNT_W       = 6;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    // Stream packing
    localparam int S_TDATA_W   = ((SAMPLE_BITS + 1 + 7) / 8) * 8;
    localparam int FLOAT_BIT   = SAMPLE_BITS;
    localparam int M_PCT_LSB   = 0;
    localparam int M_EMPTY_LSB = M_PCT_LSB + PCT_W;
    localparam int M_FULL_LSB  = M_EMPTY_LSB + LEVEL_W;
    localparam int M_VALID_BIT = M_FULL_LSB + LEVEL_W;
    localparam int M_TDATA_W   = ((M_VALID_BIT + 1 + 7) / 8) * 8;

    // Arithmetic unit widths: quotient never exceeds 100, so 7 quotient bits
    localparam int QUO_W       = 7;
    localparam int NUM_W       = SAMPLE_BITS + 7;
    localparam int DSH_W       = LEVEL_W + QUO_W - 1;
    localparam int ACC_W       = ((NUM_W > DSH_W) ? NUM_W : DSH_W) + 1;
    localparam int MUL_STEPS   = HEIGHT_W;
    localparam int DIV_STEPS   = QUO_W;
    localparam int STEP_W      = $clog2(MUL_STEPS);

    // Constants of the behavior
    localparam logic [PCT_W-1:0]    PCT_FULL    = PCT_W'(100);
    localparam logic [PCT_W-1:0]    PCT_ZERO    = '0;
    localparam logic [PCT_W-1:0]    PCT_UNSET   = PCT_W'(254);
    localparam logic [CNT_W-1:0]    SETTLE_MAX  = CNT_W'(40);
    localparam logic [7:0]          UNSET_BYTE  = 8'hFF;
    localparam logic [LEVEL_W-1:0]  LEVEL_RESET = '1;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = '1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_EMPTY_INIT = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_INIT  = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_METRE  = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT     = CFG_ADDR_W'(3);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed {
        logic                start;
        op_t                 op;
        logic [ACC_W-1:0]    acc_init;
        logic [DSH_W-1:0]    opnd_init;
        logic [HEIGHT_W-1:0] mplr;
    } unit_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] result;
    } unit_rsp_t;

    function automatic logic level_set(input logic [LEVEL_W-1:0] v);
        return v[LEVEL_W-1 -: 8] != UNSET_BYTE;
    endfunction

endpackage

// ===== sv/tlpa_arith_unit.sv =====
// Shared add/subtract unit: shift-add multiply or restoring divide, one bit per cycle
module tlpa_arith_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  tlpa_pkg::unit_req_t req,
    output tlpa_pkg::unit_rsp_t rsp
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    tlpa_pkg::op_t                       op_reg, op_next;
    logic [tlpa_pkg::STEP_W-1:0]         cnt_reg, cnt_next;
    logic [tlpa_pkg::ACC_W-1:0]          acc_reg, acc_next;
    logic [tlpa_pkg::DSH_W-1:0]          opnd_reg, opnd_next;
    logic [tlpa_pkg::HEIGHT_W-1:0]       mplr_reg, mplr_next;
    logic [tlpa_pkg::QUO_W-1:0]          quo_reg, quo_next;

    logic [tlpa_pkg::ACC_W-1:0]          addend;
    logic [tlpa_pkg::ACC_W-1:0]          sum;
    logic                                is_div;
    logic                                last_step;
    logic                                fits;

    assign is_div    = (op_reg == tlpa_pkg::OP_DIV);
    assign last_step = is_div ? (cnt_reg == tlpa_pkg::STEP_W'(tlpa_pkg::DIV_STEPS - 1))
                              : (cnt_reg == tlpa_pkg::STEP_W'(tlpa_pkg::MUL_STEPS - 1));

    // The one adder: remainder minus shifted divisor, or accumulator plus partial product
    always_comb begin
        if (is_div) begin
            addend = ~tlpa_pkg::ACC_W'(opnd_reg);
        end else if (mplr_reg[0]) begin
            addend = tlpa_pkg::ACC_W'(opnd_reg);
        end else begin
            addend = '0;
        end
        sum  = acc_reg + addend + tlpa_pkg::ACC_W'(is_div);
        fits = ~sum[tlpa_pkg::ACC_W-1];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        opnd_next = opnd_reg;
        mplr_next = mplr_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            acc_next  = req.acc_init;
            opnd_next = req.opnd_init;
            mplr_next = req.mplr;
            quo_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + tlpa_pkg::STEP_W'(1);
            if (is_div) begin
                if (fits) begin
                    acc_next = sum;
                end
                quo_next  = {quo_reg[tlpa_pkg::QUO_W-2:0], fits};
                opnd_next = opnd_reg >> 1;
            end else begin
                acc_next  = sum;
                opnd_next = opnd_reg << 1;
                mplr_next = mplr_reg >> 1;
            end
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= tlpa_pkg::OP_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        opnd_reg <= opnd_next;
        mplr_reg <= mplr_next;
        quo_reg  <= quo_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = is_div ? tlpa_pkg::LEVEL_W'(quo_reg)
                               : acc_reg[tlpa_pkg::LEVEL_W-1:0];

endmodule

// ===== sv/tank_level_percent_autocal.sv =====
// Channel   | Direction | Handshake          | Contents
// ----------+-----------+--------------------+------------------------------------------
// s_        | in        | s_tvalid/s_tready  | tdata: sample, float_high; tuser: mode
// m_        | out       | m_tvalid/m_tready  | tdata: percent, empty, full, limits_valid
// cfg_      | in        | cfg_we             | cfg_addr selects register, cfg_wdata value
//
// Tracking sample (mode 0): EVAL, then DONE, where the result is registered. Report sample
// (mode 1): EVAL, MUL if the full level is derived (8-step shift-add multiply), CHECK, and
// DIV if in range (7-step restoring divide), both on the one shared add/subtract unit; then DONE.
// s_tready is high only in the idle state, entered as the result appears, so samples do not overlap.
// Reset (aresetn low, synchronous) loads all limits as unset and the percentage as 254.
// A result held by a low m_tready stalls the sequencer in its final state.
module tank_level_percent_autocal (
    input  logic                                aclk,
    input  logic                                aresetn,
    // stream in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tlpa_pkg::S_TDATA_W-1:0]      s_tdata,   // sample, float_high, zero pad
    input  logic                                s_tuser,   // mode
    // stream out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tlpa_pkg::M_TDATA_W-1:0]      m_tdata,   // percent, empty_level,
                                                           // full_level, limits_valid, pad
    // configuration writes
    input  logic                                cfg_we,
    input  logic [tlpa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tlpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    tlpa_pkg::state_t                      state_reg, state_next;

    // captured transaction
    logic                                  mode_reg, mode_next;
    logic [tlpa_pkg::SAMPLE_BITS-1:0]      sample_reg, sample_next;
    logic                                  float_reg, float_next;

    // calibration state
    logic [tlpa_pkg::LEVEL_W-1:0]          empty_reg, empty_next;
    logic [tlpa_pkg::LEVEL_W-1:0]          full_reg, full_next;
    logic [tlpa_pkg::LEVEL_W-1:0]          one_metre_reg, one_metre_next;
    logic [tlpa_pkg::HEIGHT_W-1:0]         height_reg, height_next;
    logic                                  cleared_reg, cleared_next;
    logic [tlpa_pkg::CNT_W-1:0]            low_cnt_reg, low_cnt_next;
    logic [tlpa_pkg::CNT_W-1:0]            high_cnt_reg, high_cnt_next;
    logic [tlpa_pkg::PCT_W-1:0]            pct_reg, pct_next;

    // output register
    logic                                  m_tvalid_reg, m_tvalid_next;
    logic [tlpa_pkg::M_TDATA_W-1:0]        m_tdata_reg, m_tdata_next;

    tlpa_pkg::unit_req_t                   unit_req;
    tlpa_pkg::unit_rsp_t                   unit_rsp;

    logic [tlpa_pkg::LEVEL_W-1:0]          sample_ext;
    logic                                  limits_ok;
    logic                                  derive_full;
    logic                                  in_range;
    logic                                  span_zero;
    logic [tlpa_pkg::LEVEL_W-1:0]          span;
    logic [tlpa_pkg::LEVEL_W-1:0]          offset;
    logic [tlpa_pkg::NUM_W-1:0]            scaled;
    logic                                  out_free;
    logic [tlpa_pkg::CNT_W-1:0]            low_inc;
    logic [tlpa_pkg::CNT_W-1:0]            high_inc;

    tlpa_arith_unit u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (unit_req),
        .rsp     (unit_rsp)
    );

    // Conditions shared by the sequencer and the datapath
    always_comb begin
        sample_ext  = tlpa_pkg::LEVEL_W'(sample_reg);
        limits_ok   = tlpa_pkg::level_set(empty_reg) && tlpa_pkg::level_set(full_reg);
        derive_full = tlpa_pkg::level_set(one_metre_reg) && !cleared_reg
                      && tlpa_pkg::level_set(empty_reg)
                      && (height_reg != tlpa_pkg::HEIGHT_RESET)
                      && !tlpa_pkg::level_set(full_reg);
        in_range    = limits_ok && (sample_ext >= empty_reg) && (sample_ext <= full_reg);
        span        = full_reg - empty_reg;
        span_zero   = (span == '0);
        offset      = sample_ext - empty_reg;
        // offset fits the sample width whenever the sample is in range
        scaled      = tlpa_pkg::NUM_W'(offset[tlpa_pkg::SAMPLE_BITS-1:0])
                      * tlpa_pkg::NUM_W'(tlpa_pkg::PCT_FULL);
        out_free    = !m_tvalid_reg || m_tready;
        low_inc     = low_cnt_reg + tlpa_pkg::CNT_W'(1);
        high_inc    = high_cnt_reg + tlpa_pkg::CNT_W'(1);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tlpa_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = tlpa_pkg::ST_EVAL;
                end
            end
            tlpa_pkg::ST_EVAL: begin
                if (!mode_reg) begin
                    state_next = tlpa_pkg::ST_DONE;
                end else if (derive_full) begin
                    state_next = tlpa_pkg::ST_MUL;
                end else begin
                    state_next = tlpa_pkg::ST_CHECK;
                end
            end
            tlpa_pkg::ST_MUL: begin
                if (unit_rsp.done) begin
                    state_next = tlpa_pkg::ST_CHECK;
                end
            end
            tlpa_pkg::ST_CHECK: begin
                if (in_range && !span_zero) begin
                    state_next = tlpa_pkg::ST_DIV;
                end else begin
                    state_next = tlpa_pkg::ST_DONE;
                end
            end
            tlpa_pkg::ST_DIV: begin
                if (unit_rsp.done) begin
                    state_next = tlpa_pkg::ST_DONE;
                end
            end
            tlpa_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = tlpa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tlpa_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        mode_next      = mode_reg;
        sample_next    = sample_reg;
        float_next     = float_reg;
        empty_next     = empty_reg;
        full_next      = full_reg;
        one_metre_next = one_metre_reg;
        height_next    = height_reg;
        cleared_next   = cleared_reg;
        low_cnt_next   = low_cnt_reg;
        high_cnt_next  = high_cnt_reg;
        pct_next       = pct_reg;
        m_tdata_next   = m_tdata_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        s_tready       = 1'b0;

        unit_req.start     = 1'b0;
        unit_req.op        = tlpa_pkg::OP_MUL;
        unit_req.acc_init  = '0;
        unit_req.opnd_init = tlpa_pkg::DSH_W'(one_metre_reg - empty_reg);
        unit_req.mplr      = height_reg;

        case (state_reg)
            tlpa_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                mode_next   = s_tuser;
                sample_next = s_tdata[tlpa_pkg::SAMPLE_BITS-1:0];
                float_next  = s_tdata[tlpa_pkg::FLOAT_BIT];
            end
            tlpa_pkg::ST_EVAL: begin
                if (!mode_reg) begin
                    // tracking: push the limits toward persistent excursions
                    if (limits_ok) begin
                        if (sample_ext < empty_reg) begin
                            pct_next     = tlpa_pkg::PCT_ZERO;
                            low_cnt_next = low_inc;
                            if (low_inc > tlpa_pkg::SETTLE_MAX) begin
                                low_cnt_next = '0;
                                empty_next   = sample_ext;
                            end
                        end
                        if (sample_ext > full_reg) begin
                            pct_next = tlpa_pkg::PCT_FULL;
                            if (!float_reg) begin
                                high_cnt_next = high_inc;
                                if (high_inc > tlpa_pkg::SETTLE_MAX) begin
                                    high_cnt_next = '0;
                                    full_next     = sample_ext;
                                end
                            end
                        end
                    end
                end else if (derive_full) begin
                    // full = (one metre - empty) * height, kept modulo 2^16
                    unit_req.start = 1'b1;
                end
            end
            tlpa_pkg::ST_MUL: begin
                if (unit_rsp.done) begin
                    full_next    = unit_rsp.result;
                    cleared_next = 1'b1;
                end
            end
            tlpa_pkg::ST_CHECK: begin
                if (in_range) begin
                    low_cnt_next  = '0;
                    high_cnt_next = '0;
                    if (span_zero) begin
                        pct_next = tlpa_pkg::PCT_ZERO;
                    end else begin
                        unit_req.start     = 1'b1;
                        unit_req.op        = tlpa_pkg::OP_DIV;
                        unit_req.acc_init  = tlpa_pkg::ACC_W'(scaled);
                        unit_req.opnd_init = tlpa_pkg::DSH_W'(span) << (tlpa_pkg::QUO_W - 1);
                        unit_req.mplr      = '0;
                    end
                end
            end
            tlpa_pkg::ST_DIV: begin
                if (unit_rsp.done) begin
                    pct_next = unit_rsp.result[tlpa_pkg::PCT_W-1:0];
                end
            end
            tlpa_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[tlpa_pkg::M_PCT_LSB +: tlpa_pkg::PCT_W]     = pct_reg;
                    m_tdata_next[tlpa_pkg::M_EMPTY_LSB +: tlpa_pkg::LEVEL_W] = empty_reg;
                    m_tdata_next[tlpa_pkg::M_FULL_LSB +: tlpa_pkg::LEVEL_W]  = full_reg;
                    m_tdata_next[tlpa_pkg::M_VALID_BIT]                      = limits_ok;
                end
            end
            default: begin
            end
        endcase

        // Configuration must arrive only while idle; the block itself does not enforce this
        if (cfg_we) begin
            case (cfg_addr)
                tlpa_pkg::REG_EMPTY_INIT: empty_next = cfg_wdata;
                tlpa_pkg::REG_FULL_INIT:  full_next  = cfg_wdata;
                tlpa_pkg::REG_ONE_METRE: begin
                    one_metre_next = cfg_wdata;
                    cleared_next   = 1'b0;
                end
                tlpa_pkg::REG_HEIGHT:     height_next = cfg_wdata[tlpa_pkg::HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tlpa_pkg::ST_IDLE;
            empty_reg     <= tlpa_pkg::LEVEL_RESET;
            full_reg      <= tlpa_pkg::LEVEL_RESET;
            one_metre_reg <= tlpa_pkg::LEVEL_RESET;
            height_reg    <= tlpa_pkg::HEIGHT_RESET;
            cleared_reg   <= 1'b0;
            low_cnt_reg   <= '0;
            high_cnt_reg  <= '0;
            pct_reg       <= tlpa_pkg::PCT_UNSET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            empty_reg     <= empty_next;
            full_reg      <= full_next;
            one_metre_reg <= one_metre_next;
            height_reg    <= height_next;
            cleared_reg   <= cleared_next;
            low_cnt_reg   <= low_cnt_next;
            high_cnt_reg  <= high_cnt_next;
            pct_reg       <= pct_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload: hold the captured transaction and the result word
    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        sample_reg  <= sample_next;
        float_reg   <= float_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/tlpa_checker.sv =====
module tlpa_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tlpa_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [tlpa_pkg::PCT_W-1:0]   pct;
    logic [tlpa_pkg::LEVEL_W-1:0] empty_lvl;
    logic [tlpa_pkg::LEVEL_W-1:0] full_lvl;

    assign pct       = m_tdata[tlpa_pkg::M_PCT_LSB +: tlpa_pkg::PCT_W];
    assign empty_lvl = m_tdata[tlpa_pkg::M_EMPTY_LSB +: tlpa_pkg::LEVEL_W];
    assign full_lvl  = m_tdata[tlpa_pkg::M_FULL_LSB +: tlpa_pkg::LEVEL_W];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new transaction taken while one is in work");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pct <= tlpa_pkg::PCT_FULL) || (pct == tlpa_pkg::PCT_UNSET))
        else $error("percentage out of range");

    a_limits_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[tlpa_pkg::M_VALID_BIT]
                     == (tlpa_pkg::level_set(empty_lvl) && tlpa_pkg::level_set(full_lvl)))
        else $error("limits_valid disagrees with reported levels");

endmodule

bind tank_level_percent_autocal tlpa_checker u_tlpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
